### rtl/efu_pkg.sv
// Shared constants and types of the escaped frame unpacker.
package efu_pkg;

  localparam int PLAYERS_DEF      = 8;
  localparam int BUFFER_BYTES_DEF = 16;

  localparam int CMD_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int PSEL_W    = 3;
  localparam int ESEL_W    = 4;
  localparam int FPL_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_STREAM = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd2;

  localparam logic [BYTE_W-1:0] START_RST  = 8'd126;
  localparam logic [BYTE_W-1:0] STOP_RST   = 8'd127;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd125;

  typedef struct packed {
    logic wr;
    logic mark;
    logic emit;
    logic done;
    logic err;
  } dfr_act_t;

  typedef struct packed {
    logic              done;
    logic [FPL_W-1:0]  player;
    logic [BYTE_W-1:0] data;
    logic              ready;
    logic              err;
  } res_t;

endpackage

### rtl/efu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module efu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### rtl/efu_deframer.sv
// Stream byte decoder: frame, escape and player tracking plus delimiter registers.
module efu_deframer #(
  parameter int PLAYERS      = efu_pkg::PLAYERS_DEF,
  parameter int BUFFER_BYTES = efu_pkg::BUFFER_BYTES_DEF,
  localparam int PLW = (PLAYERS > 1) ? $clog2(PLAYERS) : 1,
  localparam int FW  = $clog2(BUFFER_BYTES + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [efu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efu_pkg::BYTE_W-1:0]     cfg_wdata,
  input  logic                           step,
  input  logic [efu_pkg::BYTE_W-1:0]     byte_value,
  output efu_pkg::dfr_act_t              act,
  output logic [PLW-1:0]                 cur_player,
  output logic [FW-1:0]                  fill
);

  logic [efu_pkg::BYTE_W-1:0] start_r, stop_r, escb_r;
  logic                       in_frame_r, esc_r, known_r;
  logic                       in_frame_nxt, esc_nxt, known_nxt;
  logic [PLW-1:0]             cp_r, cp_nxt;
  logic [FW-1:0]              fill_r, fill_nxt;
  logic                       data_byte, byte_ok, fill_open;

  assign byte_ok    = 32'(byte_value) < PLAYERS;
  assign fill_open  = 32'(fill_r) < BUFFER_BYTES;
  assign cur_player = cp_r;
  assign fill       = fill_r;

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    known_nxt    = known_r;
    cp_nxt       = cp_r;
    fill_nxt     = fill_r;
    act          = '0;
    data_byte    = 1'b0;
    if (!in_frame_r) begin
      if (byte_value == start_r) begin
        in_frame_nxt = 1'b1;
        esc_nxt      = 1'b0;
        known_nxt    = 1'b0;
        cp_nxt       = '0;
        fill_nxt     = '0;
      end
    end else if (esc_r) begin
      esc_nxt   = 1'b0;
      data_byte = 1'b1;
    end else if (byte_value == escb_r) begin
      esc_nxt = 1'b1;
    end else if (byte_value == start_r) begin
      fill_nxt  = '0;
      known_nxt = 1'b0;
      cp_nxt    = '0;
    end else if (byte_value == stop_r) begin
      fill_nxt     = '0;
      in_frame_nxt = 1'b0;
      act.emit     = 1'b1;
      act.done     = 1'b1;
      act.mark     = known_r;
      act.err      = !known_r;
      known_nxt    = 1'b0;
      cp_nxt       = '0;
    end else begin
      data_byte = 1'b1;
    end
    if (data_byte) begin
      if (!known_r) begin
        if (byte_ok) begin
          cp_nxt    = PLW'(byte_value);
          known_nxt = 1'b1;
        end else begin
          act.emit = 1'b1;
          act.err  = 1'b1;
        end
      end else if (fill_open) begin
        act.wr   = 1'b1;
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= efu_pkg::START_RST;
      stop_r     <= efu_pkg::STOP_RST;
      escb_r     <= efu_pkg::ESCAPE_RST;
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      known_r    <= 1'b0;
      cp_r       <= '0;
      fill_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          efu_pkg::REG_START:  start_r <= cfg_wdata;
          efu_pkg::REG_STOP:   stop_r  <= cfg_wdata;
          efu_pkg::REG_ESCAPE: escb_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (step) begin
        in_frame_r <= in_frame_nxt;
        esc_r      <= esc_nxt;
        known_r    <= known_nxt;
        cp_r       <= cp_nxt;
        fill_r     <= fill_nxt;
      end
    end
  end

endmodule

### rtl/escaped_frame_unpacker.sv
// Top level: byte-stuffed frame deframer with per-player buffers in RAM.
//
//  port group | direction | handshake           | payload
//  in_        | input     | in_valid / in_ready | command, byte_value, player_select, entry_select
//  out_       | output    | out_valid/out_ready | frame_done, frame_player, read_data, ready_flag,
//             |           |                     | error_flag
//  cfg_       | input     | cfg_we              | cfg_index, cfg_wdata
//
// Stream and clear words are handled when accepted; a read goes on to the ST_RD state,
// which takes its data from the buffer RAM's registered read port.
// Reset is synchronous; per-player fill marks and ready flags sit in
// flops, so unwritten buffer entries read as zero without a clearing pass.
// A result waits in the output register; a word that must report while it waits
// parks its result and holds in_ready low until the output register frees.
module escaped_frame_unpacker #(
  parameter int PLAYERS      = efu_pkg::PLAYERS_DEF,
  parameter int BUFFER_BYTES = efu_pkg::BUFFER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [efu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efu_pkg::BYTE_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [efu_pkg::CMD_W-1:0]      in_command,
  input  logic [efu_pkg::BYTE_W-1:0]     in_byte_value,
  input  logic [efu_pkg::PSEL_W-1:0]     in_player_select,
  input  logic [efu_pkg::ESEL_W-1:0]     in_entry_select,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_frame_done,
  output logic [efu_pkg::FPL_W-1:0]      out_frame_player,
  output logic [efu_pkg::BYTE_W-1:0]     out_read_data,
  output logic                           out_ready_flag,
  output logic                           out_error_flag
);

  localparam int PLW   = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
  localparam int FW    = $clog2(BUFFER_BYTES + 1);
  localparam int DEPTH = PLAYERS * BUFFER_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic                       acc, slot_free;
  efu_pkg::dfr_act_t          act;
  logic [PLW-1:0]             cp, pidx, hidx;
  logic [FW-1:0]              fill, fill_inc, hwm_rd;
  logic [FW-1:0]              hwm_r [PLAYERS];
  logic [PLAYERS-1:0]         rdy_r;
  logic                       p_ok, e_ok, hit;
  logic                       hit_r, rflag_r;
  logic                       step, ram_we, ram_re, start_rd, clr;
  logic [AW-1:0]              waddr, raddr;
  logic [efu_pkg::BYTE_W-1:0] rdata;
  logic                       imm_emit, load;
  efu_pkg::res_t              imm_res, rd_res, load_res, pend_r, pend_nxt, out_r;
  logic                       out_valid_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign pidx     = PLW'(in_player_select);
  assign p_ok     = 32'(in_player_select) < PLAYERS;
  assign e_ok     = 32'(in_entry_select) < BUFFER_BYTES;
  assign hidx     = (in_command == efu_pkg::CMD_STREAM) ? cp : pidx;
  assign hwm_rd   = hwm_r[hidx];
  assign hit      = p_ok && e_ok && (32'(in_entry_select) < 32'(hwm_rd));
  assign fill_inc = fill + 1'b1;

  assign waddr = AW'(32'(cp) * BUFFER_BYTES + 32'(fill));
  assign raddr = AW'(32'(pidx) * BUFFER_BYTES + 32'(in_entry_select));

  efu_deframer #(
    .PLAYERS      (PLAYERS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dfr (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .step       (step),
    .byte_value (in_byte_value),
    .act        (act),
    .cur_player (cp),
    .fill       (fill)
  );

  efu_ram #(
    .WIDTH (efu_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_byte_value),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    step     = 1'b0;
    start_rd = 1'b0;
    clr      = 1'b0;
    imm_emit = 1'b0;
    imm_res  = '0;
    unique case (in_command)
      efu_pkg::CMD_STREAM: begin
        step           = acc;
        imm_emit       = act.emit;
        imm_res.done   = act.done;
        imm_res.err    = act.err;
        imm_res.player = act.mark ? efu_pkg::FPL_W'(cp) : '0;
      end
      efu_pkg::CMD_READ: begin
        if (p_ok && e_ok) begin
          start_rd = 1'b1;
        end else begin
          imm_emit    = 1'b1;
          imm_res.err = 1'b1;
        end
      end
      efu_pkg::CMD_CLEAR: begin
        if (p_ok) begin
          clr = 1'b1;
        end else begin
          imm_emit    = 1'b1;
          imm_res.err = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign ram_we = step && act.wr;
  assign ram_re = acc && start_rd;

  always_comb begin
    rd_res       = '0;
    rd_res.data  = hit_r ? rdata : '0;
    rd_res.ready = rflag_r;
  end

  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    load_res  = imm_res;
    pend_nxt  = pend_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (start_rd) begin
            state_nxt = ST_RD;
          end else if (imm_emit) begin
            if (slot_free) begin
              load = 1'b1;
            end else begin
              pend_nxt  = imm_res;
              state_nxt = ST_HOLD;
            end
          end
        end
      end
      ST_RD: begin
        load_res = rd_res;
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          pend_nxt  = rd_res;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        load_res = pend_r;
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rdy_r       <= '0;
      for (int i = 0; i < PLAYERS; i++) begin
        hwm_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we && (fill_inc > hwm_rd)) begin
        hwm_r[cp] <= fill_inc;
      end
      if (step && act.mark) begin
        rdy_r[cp] <= 1'b1;
      end
      if (acc && clr) begin
        hwm_r[pidx] <= '0;
        rdy_r[pidx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (load) begin
      out_r <= load_res;
    end
    if (ram_re) begin
      hit_r   <= hit;
      rflag_r <= rdy_r[pidx];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_done   = out_r.done;
  assign out_frame_player = out_r.player;
  assign out_read_data    = out_r.data;
  assign out_ready_flag   = out_r.ready;
  assign out_error_flag   = out_r.err;

endmodule

### rtl/efu_checker.sv
// Port-level checks of the escaped frame unpacker, bound to the top level.
module efu_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_frame_done,
  input logic [efu_pkg::FPL_W-1:0]      out_frame_player,
  input logic [efu_pkg::BYTE_W-1:0]     out_read_data,
  input logic                           out_ready_flag,
  input logic                           out_error_flag
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_done) &&
      $stable(out_frame_player) && $stable(out_read_data) &&
      $stable(out_ready_flag) && $stable(out_error_flag))
    else $error("result word changed while stalled");

  a_done_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_read_data == 8'd0 && !out_ready_flag)
    else $error("frame report carries read data");

  a_player_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |-> out_frame_player == 3'd0)
    else $error("player reported without frame close");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |-> out_frame_player == 3'd0 &&
      out_read_data == 8'd0 && !out_ready_flag)
    else $error("error word carries payload");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind escaped_frame_unpacker efu_checker u_efu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_frame_done   (out_frame_done),
  .out_frame_player (out_frame_player),
  .out_read_data    (out_read_data),
  .out_ready_flag   (out_ready_flag),
  .out_error_flag   (out_error_flag)
);

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for escaped_frame_unpacker: frames, reads, clears and register settings.
module testbench;

  localparam logic [efu_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 62;
  localparam int SETTLE_CYCLES = 8;

  class unpacker_scoreboard;
    logic [efu_pkg::BYTE_W-1:0] start_val, stop_val, esc_val;
    bit in_frame, esc_pending, player_known;
    logic [efu_pkg::FPL_W-1:0] cur_player;
    int unsigned fill;
    logic [efu_pkg::BYTE_W-1:0] buffers [efu_pkg::PLAYERS_DEF][efu_pkg::BUFFER_BYTES_DEF];
    bit ready_marks [efu_pkg::PLAYERS_DEF];
    efu_pkg::res_t owed_results[$];
    int unsigned mismatches;

    function new();
      start_val = efu_pkg::START_RST;
      stop_val = efu_pkg::STOP_RST;
      esc_val = efu_pkg::ESCAPE_RST;
      in_frame = 0;
      esc_pending = 0;
      player_known = 0;
      cur_player = '0;
      fill = 0;
      mismatches = 0;
      foreach (buffers[p, e]) buffers[p][e] = '0;
      foreach (ready_marks[p]) ready_marks[p] = 0;
    endfunction

    function void set_reg(logic [efu_pkg::CFG_IDX_W-1:0] idx, logic [efu_pkg::BYTE_W-1:0] v);
      case (idx)
        efu_pkg::REG_START: start_val = v;
        efu_pkg::REG_STOP: stop_val = v;
        efu_pkg::REG_ESCAPE: esc_val = v;
        default: ;
      endcase
    endfunction

    function void owe(bit done, logic [efu_pkg::FPL_W-1:0] pl, logic [efu_pkg::BYTE_W-1:0] d,
                      bit rdy, bit err);
      efu_pkg::res_t r;
      r = {done, pl, d, rdy, err};
      owed_results.push_back(r);
    endfunction

    function void take_data(logic [efu_pkg::BYTE_W-1:0] b);
      if (!player_known) begin
        if (int'(b) < efu_pkg::PLAYERS_DEF) begin
          cur_player = b[efu_pkg::FPL_W-1:0];
          player_known = 1;
        end else begin
          owe(0, 0, 0, 0, 1);
        end
      end else if (fill < efu_pkg::BUFFER_BYTES_DEF) begin
        buffers[cur_player][efu_pkg::ESEL_W'(fill)] = b;
        fill++;
      end
    endfunction

    function void take_stream(logic [efu_pkg::BYTE_W-1:0] b);
      if (!in_frame) begin
        if (b == start_val) begin
          in_frame = 1;
          esc_pending = 0;
          player_known = 0;
          cur_player = '0;
          fill = 0;
        end
      end else if (esc_pending) begin
        esc_pending = 0;
        take_data(b);
      end else if (b == esc_val) begin
        esc_pending = 1;
      end else if (b == start_val) begin
        fill = 0;
        player_known = 0;
        cur_player = '0;
      end else if (b == stop_val) begin
        fill = 0;
        in_frame = 0;
        if (player_known) begin
          ready_marks[cur_player] = 1;
          owe(1, cur_player, 0, 0, 0);
        end else begin
          owe(1, 0, 0, 0, 1);
        end
        player_known = 0;
        cur_player = '0;
      end else begin
        take_data(b);
      end
    endfunction

    function void note_word(logic [efu_pkg::CMD_W-1:0] cmd, logic [efu_pkg::BYTE_W-1:0] b,
                            logic [efu_pkg::PSEL_W-1:0] p, logic [efu_pkg::ESEL_W-1:0] e);
      case (cmd)
        efu_pkg::CMD_STREAM: take_stream(b);
        efu_pkg::CMD_READ: begin
          if (int'(p) < efu_pkg::PLAYERS_DEF && int'(e) < efu_pkg::BUFFER_BYTES_DEF)
            owe(0, 0, buffers[p][e], ready_marks[p], 0);
          else
            owe(0, 0, 0, 0, 1);
        end
        efu_pkg::CMD_CLEAR: begin
          if (int'(p) < efu_pkg::PLAYERS_DEF) begin
            for (int i = 0; i < efu_pkg::BUFFER_BYTES_DEF; i++) buffers[p][i] = '0;
            ready_marks[p] = 0;
          end else begin
            owe(0, 0, 0, 0, 1);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(efu_pkg::res_t got);
      efu_pkg::res_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        want = owed_results.pop_front();
        if (got.done !== want.done)
          report($sformatf("frame_done got %0d want %0d", got.done, want.done));
        if (got.player !== want.player)
          report($sformatf("frame_player got %0d want %0d", got.player, want.player));
        if (got.data !== want.data)
          report($sformatf("read_data got %0d want %0d", got.data, want.data));
        if (got.ready !== want.ready)
          report($sformatf("ready_flag got %0d want %0d", got.ready, want.ready));
        if (got.err !== want.err)
          report($sformatf("error_flag got %0d want %0d", got.err, want.err));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [efu_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [efu_pkg::BYTE_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [efu_pkg::CMD_W-1:0] in_command;
  logic [efu_pkg::BYTE_W-1:0] in_byte_value;
  logic [efu_pkg::PSEL_W-1:0] in_player_select;
  logic [efu_pkg::ESEL_W-1:0] in_entry_select;
  logic out_valid;
  logic out_ready;
  logic out_frame_done;
  logic [efu_pkg::FPL_W-1:0] out_frame_player;
  logic [efu_pkg::BYTE_W-1:0] out_read_data;
  logic out_ready_flag;
  logic out_error_flag;

  unpacker_scoreboard sb;
  bit calm;
  int unsigned words_sent;

  escaped_frame_unpacker dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_byte_value(in_byte_value), .in_player_select(in_player_select),
    .in_entry_select(in_entry_select),
    .out_valid(out_valid), .out_ready(out_ready), .out_frame_done(out_frame_done),
    .out_frame_player(out_frame_player), .out_read_data(out_read_data),
    .out_ready_flag(out_ready_flag), .out_error_flag(out_error_flag)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_frame_done, out_frame_player, out_read_data,
                       out_ready_flag, out_error_flag});
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_word(logic [efu_pkg::CMD_W-1:0] cmd, logic [efu_pkg::BYTE_W-1:0] b,
                           logic [efu_pkg::PSEL_W-1:0] p, logic [efu_pkg::ESEL_W-1:0] e);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_byte_value <= b;
    in_player_select <= p;
    in_entry_select <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(cmd, b, p, e);
    if (cmd != CMD_NONE) words_sent++;
  endtask

  task automatic stream(logic [efu_pkg::BYTE_W-1:0] b);
    send_word(efu_pkg::CMD_STREAM, b, efu_pkg::PSEL_W'($urandom), efu_pkg::ESEL_W'($urandom));
  endtask

  task automatic read_entry(logic [efu_pkg::PSEL_W-1:0] p, logic [efu_pkg::ESEL_W-1:0] e);
    send_word(efu_pkg::CMD_READ, efu_pkg::BYTE_W'($urandom), p, e);
  endtask

  task automatic clear_player(logic [efu_pkg::PSEL_W-1:0] p);
    send_word(efu_pkg::CMD_CLEAR, efu_pkg::BYTE_W'($urandom), p, efu_pkg::ESEL_W'($urandom));
  endtask

  function automatic logic [efu_pkg::BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return sb.start_val;
      3: return sb.stop_val;
      4: return sb.esc_val;
      default: return efu_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_data(logic [efu_pkg::BYTE_W-1:0] b);
    if (b == sb.esc_val || b == sb.start_val || b == sb.stop_val ||
        $urandom_range(0, 9) == 0)
      stream(sb.esc_val);
    stream(b);
  endtask

  task automatic send_misc();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) read_entry(efu_pkg::PSEL_W'($urandom), efu_pkg::ESEL_W'($urandom));
    else if (pick < 8) clear_player(efu_pkg::PSEL_W'($urandom));
    else send_word(CMD_NONE, efu_pkg::BYTE_W'($urandom), efu_pkg::PSEL_W'($urandom),
                   efu_pkg::ESEL_W'($urandom));
  endtask

  task automatic send_frame();
    int len;
    int ending;
    logic [efu_pkg::BYTE_W-1:0] id;
    stream(sb.start_val);
    if ($urandom_range(0, 19) != 0) begin
      if ($urandom_range(0, 6) == 0)
        id = efu_pkg::BYTE_W'($urandom_range(efu_pkg::PLAYERS_DEF, 255));
      else
        id = efu_pkg::BYTE_W'($urandom_range(0, efu_pkg::PLAYERS_DEF - 1));
      send_data(id);
    end
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 22) : $urandom_range(0, 16);
    repeat (len) begin
      if ($urandom_range(0, 11) == 0) send_misc();
      send_data(pick_byte());
    end
    ending = $urandom_range(0, 11);
    if (ending < 9) stream(sb.stop_val);
    else if (ending == 9) stream(sb.start_val);
    else if (ending == 10) stream(sb.esc_val);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [efu_pkg::CFG_IDX_W-1:0] idx, logic [efu_pkg::BYTE_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  initial begin
    logic [efu_pkg::BYTE_W-1:0] phase_start [PHASES];
    logic [efu_pkg::BYTE_W-1:0] phase_stop [PHASES];
    logic [efu_pkg::BYTE_W-1:0] phase_esc [PHASES];
    int pick;
    phase_start = '{8'd126, 8'd0, 8'd255, 8'd5, 8'd9, 8'd126};
    phase_stop = '{8'd127, 8'd255, 8'd0, 8'd6, 8'd9, 8'd127};
    phase_esc = '{8'd125, 8'd128, 8'd1, 8'd5, 8'd8, 8'd125};
    sb = new();
    calm = 0;
    words_sent = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_command <= efu_pkg::CMD_STREAM;
    in_byte_value <= '0;
    in_player_select <= '0;
    in_entry_select <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    stream(8'd0);
    stream(efu_pkg::START_RST);
    stream(efu_pkg::STOP_RST);
    stream(efu_pkg::START_RST);
    stream(8'd200);
    stream(efu_pkg::ESCAPE_RST);
    stream(8'd3);
    stream(efu_pkg::ESCAPE_RST);
    stream(efu_pkg::START_RST);
    stream(8'd255);
    stream(8'd0);
    stream(efu_pkg::START_RST);
    stream(8'd7);
    stream(efu_pkg::ESCAPE_RST);
    stream(efu_pkg::STOP_RST);
    stream(efu_pkg::STOP_RST);
    read_entry(3'd7, 4'd0);
    read_entry(3'd3, 4'd1);
    send_word(CMD_NONE, 8'hff, 3'd7, 4'd15);
    clear_player(3'd7);
    read_entry(3'd7, 4'd15);
    read_entry(3'd0, 4'd15);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        write_reg(efu_pkg::REG_START, phase_start[ph]);
        write_reg(efu_pkg::REG_STOP, phase_stop[ph]);
        write_reg(efu_pkg::REG_ESCAPE, phase_esc[ph]);
        cfg_we <= 1'b0;
      end
      calm = (ph == PHASES - 1);
      words_sent = 0;
      while (words_sent < PHASE_WORDS) begin
        pick = $urandom_range(0, 19);
        if (pick < 11) send_frame();
        else if (pick < 17) send_misc();
        else stream(efu_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end

    settle();
    if (sb.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

### files.f
rtl/efu_pkg.sv
rtl/efu_ram.sv
rtl/efu_deframer.sv
rtl/escaped_frame_unpacker.sv
rtl/efu_checker.sv
test/testbench.sv
